FILE: hw/rtl/mips_pkg.sv
// Package for the MIPS32 subset execute step: opcodes, states and helpers.
// No dependencies.
`timescale 1ns / 1ps
package mips_pkg;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_REGIMM  = 6'h01;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_SLTIU   = 6'h0B;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_COP0    = 6'h10;
   localparam logic [5:0] OP_SPECIAL2 = 6'h1C;
   localparam logic [5:0] OP_SPECIAL3 = 6'h1F;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SW      = 6'h2B;

   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRA  = 6'h03;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_MOVZ = 6'h0A;
   localparam logic [5:0] FN_MOVN = 6'h0B;
   localparam logic [5:0] FN_MFHI = 6'h10;
   localparam logic [5:0] FN_MFLO = 6'h12;
   localparam logic [5:0] FN_MULT = 6'h18;
   localparam logic [5:0] FN_DIV  = 6'h1A;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_SLT  = 6'h2A;
   localparam logic [5:0] FN_MUL  = 6'h02;
   localparam logic [5:0] FN_EXT  = 6'h00;
   localparam logic [5:0] FN_WAIT = 6'h20;

   localparam logic [31:0] REGION_MASK = 32'hF000_0000;
   localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_UNSUP  = 2'd1;
   localparam logic [1:0] ST_HALTED = 2'd2;
   localparam logic [1:0] ST_KIND   = 2'd3;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_RESP
   } state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quot;
      logic [31:0] rem;
   } div_rsp_type;

endpackage

FILE: hw/rtl/mips_div.sv
// Signed 32-bit divider, one quotient bit per cycle (restoring).
// Depends on mips_pkg.
`timescale 1ns / 1ps
module mips_div (
   input  logic                  clock,
   input  logic                  reset,
   input  mips_pkg::div_req_type req,
   output mips_pkg::div_rsp_type rsp
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        nq_ff, nq_in;
   logic        nr_ff, nr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] shifted;

   always_comb begin
      shifted = {rem_ff[30:0], quo_ff[31]};
      trial   = {1'b0, shifted} - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      nq_in   = nq_ff;
      nr_in   = nr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
         dvs_in  = req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
         nq_in   = req.dividend[31] ^ req.divisor[31];
         nr_in   = req.dividend[31];
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!rem_ff[31] && !trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else if (rem_ff[31]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      nq_ff  <= nq_in;
      nr_ff  <= nr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = nq_ff ? (32'd0 - quo_ff) : quo_ff;
   assign rsp.rem  = nr_ff ? (32'd0 - rem_ff) : rem_ff;

endmodule

FILE: hw/rtl/mips32_subset_execute_step.sv
// Top level of the MIPS32 subset execute step: register file memory, decode, execute.
// Depends on mips_pkg and mips_div.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | func, instr_word, load_data
//   rsp     | out       | rsp_valid / rsp_ready  | next_pc, mem_*, wait_load, status, halted
//   csr     | in        | csr_write_enable       | start_address
//
// The register file is read at the accepting edge of an item, the next cycle executes,
// and the result is offered in the cycle after that. A DIV with a nonzero divisor
// first waits in the serial divider. After reset a pass over all 32 entries clears the
// register file before the first item is taken. The result waits in the output
// register until taken; the next item is accepted in the same cycle it leaves.
`timescale 1ns / 1ps
module mips32_subset_execute_step (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_instr_word,
   input  logic [31:0] req_load_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_mem_valid,
   output logic        rsp_mem_write,
   output logic        rsp_mem_byte,
   output logic [31:0] rsp_mem_addr,
   output logic [31:0] rsp_mem_wdata,
   output logic        rsp_wait_load,
   output logic [1:0]  rsp_status,
   output logic        rsp_halted,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   mips_pkg::state_type state_ff, state_in;

   logic [31:0] regs [32];
   logic [31:0] rd_a_ff, rd_b_ff;
   logic        we;
   logic [4:0]  wa;
   logic [31:0] wd;

   logic [4:0]  clr_ff, clr_in;
   logic        func_ff, func_in;
   logic [31:0] iw_ff, iw_in;
   logic [31:0] ld_ff, ld_in;
   logic [31:0] pc_ff, pc_in;
   logic [31:0] hi_ff, hi_in;
   logic [31:0] lo_ff, lo_in;
   logic        run_ff, run_in;
   logic        lp_ff, lp_in;
   logic [4:0]  ldst_ff, ldst_in;
   logic        lbyte_ff, lbyte_in;
   logic [63:0] prod;

   logic [31:0] npc_ff, npc_in;
   logic        mv_ff, mv_in, mw_ff, mw_in, mb_ff, mb_in;
   logic [31:0] ma_ff, ma_in, mwd_ff, mwd_in;
   logic [1:0]  st_ff, st_in;

   mips_pkg::div_req_type dreq;
   mips_pkg::div_rsp_type drsp;

   mips_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sa;
   logic [31:0] imm, a, b, seq, bt, jt, ext_mask;
   logic        ok;

   assign op  = iw_ff[31:26];
   assign rs  = iw_ff[25:21];
   assign rt  = iw_ff[20:16];
   assign rd  = iw_ff[15:11];
   assign sa  = iw_ff[10:6];
   assign fn  = iw_ff[5:0];
   assign imm = {{16{iw_ff[15]}}, iw_ff[15:0]};
   assign a   = rd_a_ff;
   assign b   = rd_b_ff;
   assign seq = pc_ff + 32'd4;
   assign bt  = seq + {imm[29:0], 2'b00};
   assign jt  = (pc_ff & mips_pkg::REGION_MASK) | {4'd0, iw_ff[25:0], 2'b00};
   assign ext_mask = mips_pkg::ALL_ONES >> (5'd31 - rd);
   assign prod = $signed(a) * $signed(b);

   always_ff @(posedge clock) begin
      if (we) begin
         regs[wa] <= wd;
      end
      rd_a_ff <= regs[iw_in[25:21]];
      rd_b_ff <= regs[iw_in[20:16]];
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      func_in  = func_ff;
      iw_in    = iw_ff;
      ld_in    = ld_ff;
      pc_in    = pc_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      run_in   = run_ff;
      lp_in    = lp_ff;
      ldst_in  = ldst_ff;
      lbyte_in = lbyte_ff;
      npc_in   = npc_ff;
      mv_in    = mv_ff;
      mw_in    = mw_ff;
      mb_in    = mb_ff;
      ma_in    = ma_ff;
      mwd_in   = mwd_ff;
      st_in    = st_ff;
      we       = 1'b0;
      wa       = '0;
      wd       = '0;
      ok       = 1'b1;
      dreq.start    = 1'b0;
      dreq.dividend = a;
      dreq.divisor  = b;
      req_ready = 1'b0;

      unique case (state_ff)
         mips_pkg::S_CLEAR: begin
            we     = 1'b1;
            wa     = clr_ff;
            clr_in = clr_ff + 5'd1;
            if (clr_ff == 5'd31) begin
               state_in = mips_pkg::S_IDLE;
            end
         end
         mips_pkg::S_IDLE, mips_pkg::S_RESP: begin
            req_ready = (state_ff == mips_pkg::S_IDLE) || rsp_ready;
            if (req_valid && req_ready) begin
               func_in  = req_func;
               iw_in    = req_instr_word;
               ld_in    = req_load_data;
               state_in = mips_pkg::S_EXEC;
            end else if (state_ff == mips_pkg::S_RESP && rsp_ready) begin
               state_in = mips_pkg::S_IDLE;
            end
         end
         mips_pkg::S_EXEC: begin
            state_in = mips_pkg::S_RESP;
            mv_in  = 1'b0;
            mw_in  = 1'b0;
            mb_in  = 1'b0;
            ma_in  = '0;
            mwd_in = '0;
            st_in  = mips_pkg::ST_OK;
            if (func_ff) begin
               if (lp_ff) begin
                  we    = ldst_ff != 5'd0;
                  wa    = ldst_ff;
                  wd    = lbyte_ff ? {{24{ld_ff[7]}}, ld_ff[7:0]} : ld_ff;
                  lp_in = 1'b0;
               end else begin
                  st_in = mips_pkg::ST_KIND;
               end
            end else if (lp_ff) begin
               st_in = mips_pkg::ST_KIND;
            end else if (!run_ff) begin
               st_in = mips_pkg::ST_HALTED;
            end else begin
               pc_in = seq;
               unique case (op)
                  mips_pkg::OP_SPECIAL: begin
                     wa = rd;
                     unique case (fn)
                        mips_pkg::FN_SLL:  begin we = 1'b1; wd = b << sa; end
                        mips_pkg::FN_SRA:  begin we = 1'b1; wd = $signed(b) >>> sa; end
                        mips_pkg::FN_JR:   pc_in = a;
                        mips_pkg::FN_MOVZ: begin we = b == 32'd0; wd = a; end
                        mips_pkg::FN_MOVN: begin we = b != 32'd0; wd = a; end
                        mips_pkg::FN_MFHI: begin we = 1'b1; wd = hi_ff; end
                        mips_pkg::FN_MFLO: begin we = 1'b1; wd = lo_ff; end
                        mips_pkg::FN_MULT: begin
                           hi_in = prod[63:32];
                           lo_in = prod[31:0];
                        end
                        mips_pkg::FN_DIV: begin
                           if (b != 32'd0) begin
                              dreq.start = 1'b1;
                              state_in   = mips_pkg::S_DIV;
                           end
                        end
                        mips_pkg::FN_ADDU: begin we = 1'b1; wd = a + b; end
                        mips_pkg::FN_SUBU: begin we = 1'b1; wd = a - b; end
                        mips_pkg::FN_AND:  begin we = 1'b1; wd = a & b; end
                        mips_pkg::FN_OR:   begin we = 1'b1; wd = a | b; end
                        mips_pkg::FN_SLT:  begin
                           we = 1'b1;
                           wd = {31'd0, $signed(a) < $signed(b)};
                        end
                        default: ok = 1'b0;
                     endcase
                  end
                  mips_pkg::OP_REGIMM: begin
                     if (rt == 5'd0) begin
                        if (a[31]) pc_in = bt;
                     end else if (rt == 5'd1) begin
                        if (!a[31]) pc_in = bt;
                     end else begin
                        ok = 1'b0;
                     end
                  end
                  mips_pkg::OP_J: pc_in = jt;
                  mips_pkg::OP_JAL: begin
                     we = 1'b1; wa = 5'd31; wd = pc_ff + 32'd8; pc_in = jt;
                  end
                  mips_pkg::OP_BEQ:  if (a == b) pc_in = bt;
                  mips_pkg::OP_BNE:  if (a != b) pc_in = bt;
                  mips_pkg::OP_BLEZ: if (a[31] || a == 32'd0) pc_in = bt;
                  mips_pkg::OP_BGTZ: if (!a[31] && a != 32'd0) pc_in = bt;
                  mips_pkg::OP_ADDIU: begin we = 1'b1; wa = rt; wd = a + imm; end
                  mips_pkg::OP_SLTI: begin
                     we = 1'b1; wa = rt; wd = {31'd0, $signed(a) < $signed(imm)};
                  end
                  mips_pkg::OP_SLTIU: begin we = 1'b1; wa = rt; wd = {31'd0, a < imm}; end
                  mips_pkg::OP_ANDI: begin
                     we = 1'b1; wa = rt; wd = a & {16'd0, iw_ff[15:0]};
                  end
                  mips_pkg::OP_ORI: begin
                     we = 1'b1; wa = rt; wd = a | {16'd0, iw_ff[15:0]};
                  end
                  mips_pkg::OP_LUI: begin we = 1'b1; wa = rt; wd = {iw_ff[15:0], 16'd0}; end
                  mips_pkg::OP_COP0: begin
                     if (iw_ff[25] && fn == mips_pkg::FN_WAIT) run_in = 1'b0;
                     else ok = 1'b0;
                  end
                  mips_pkg::OP_SPECIAL2: begin
                     if (fn == mips_pkg::FN_MUL) begin
                        we = 1'b1; wa = rd; wd = prod[31:0];
                     end else begin
                        ok = 1'b0;
                     end
                  end
                  mips_pkg::OP_SPECIAL3: begin
                     if (fn == mips_pkg::FN_EXT) begin
                        we = 1'b1; wa = rt; wd = (a >> sa) & ext_mask;
                     end else begin
                        ok = 1'b0;
                     end
                  end
                  mips_pkg::OP_LB, mips_pkg::OP_LW: begin
                     mv_in    = 1'b1;
                     mb_in    = op == mips_pkg::OP_LB;
                     ma_in    = a + imm;
                     lp_in    = 1'b1;
                     ldst_in  = rt;
                     lbyte_in = op == mips_pkg::OP_LB;
                  end
                  mips_pkg::OP_SB, mips_pkg::OP_SW: begin
                     mv_in  = 1'b1;
                     mw_in  = 1'b1;
                     mb_in  = op == mips_pkg::OP_SB;
                     ma_in  = a + imm;
                     mwd_in = b;
                  end
                  default: ok = 1'b0;
               endcase
               if (wa == 5'd0) we = 1'b0;
               if (!ok) begin
                  we     = 1'b0;
                  pc_in  = pc_ff;
                  hi_in  = hi_ff;
                  lo_in  = lo_ff;
                  run_in = run_ff;
                  state_in = mips_pkg::S_RESP;
                  dreq.start = 1'b0;
                  st_in  = mips_pkg::ST_UNSUP;
               end
            end
            npc_in = pc_in;
         end
         mips_pkg::S_DIV: begin
            if (drsp.done) begin
               lo_in    = drsp.quot;
               hi_in    = drsp.rem;
               state_in = mips_pkg::S_RESP;
            end
         end
         default: state_in = mips_pkg::S_IDLE;
      endcase

      if (csr_write_enable) begin
         pc_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      iw_ff    <= iw_in;
      ld_ff    <= ld_in;
      npc_ff   <= npc_in;
      mv_ff    <= mv_in;
      mw_ff    <= mw_in;
      mb_ff    <= mb_in;
      ma_ff    <= ma_in;
      mwd_ff   <= mwd_in;
      st_ff    <= st_in;
      if (reset) begin
         state_ff <= mips_pkg::S_CLEAR;
         clr_ff   <= '0;
         pc_ff    <= '0;
         hi_ff    <= '0;
         lo_ff    <= '0;
         run_ff   <= 1'b1;
         lp_ff    <= 1'b0;
         ldst_ff  <= '0;
         lbyte_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pc_ff    <= pc_in;
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
         run_ff   <= run_in;
         lp_ff    <= lp_in;
         ldst_ff  <= ldst_in;
         lbyte_ff <= lbyte_in;
      end
   end

   assign rsp_valid     = state_ff == mips_pkg::S_RESP;
   assign rsp_next_pc   = npc_ff;
   assign rsp_mem_valid = mv_ff;
   assign rsp_mem_write = mw_ff;
   assign rsp_mem_byte  = mb_ff;
   assign rsp_mem_addr  = ma_ff;
   assign rsp_mem_wdata = mwd_ff;
   assign rsp_wait_load = lp_ff;
   assign rsp_status    = st_ff;
   assign rsp_halted    = !run_ff;

   logic unused_addr;
   assign unused_addr = drsp.busy;

endmodule

FILE: tb/tb_mips32_subset_execute_step.sv
// Testbench for mips32_subset_execute_step: directed and random instruction streams,
// checked item by item against a behavioural model of the core held in this file.
// Depends on mips_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_mips32_subset_execute_step;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        mem_valid;
      logic        mem_write;
      logic        mem_byte;
      logic [31:0] mem_addr;
      logic [31:0] mem_wdata;
      logic        wait_load;
      logic [1:0]  status;
      logic        halted;
   } core_result_type;

   localparam int WATCHDOG_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [31:0] req_instr_word = '0;
   logic [31:0] req_load_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_next_pc;
   logic        rsp_mem_valid;
   logic        rsp_mem_write;
   logic        rsp_mem_byte;
   logic [31:0] rsp_mem_addr;
   logic [31:0] rsp_mem_wdata;
   logic        rsp_wait_load;
   logic [1:0]  rsp_status;
   logic        rsp_halted;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;

   // architectural state of the core as the testbench sees it
   logic [31:0] gpr [32];
   logic [31:0] arch_pc;
   logic [31:0] arch_hi;
   logic [31:0] arch_lo;
   logic        arch_running;
   logic        load_waiting;
   logic [4:0]  load_target;
   logic        load_byte;

   core_result_type awaited_results[$];
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          hold_off_cycles = 0;

   mips32_subset_execute_step uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_instr_word   (req_instr_word),
      .req_load_data    (req_load_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_mem_valid    (rsp_mem_valid),
      .rsp_mem_write    (rsp_mem_write),
      .rsp_mem_byte     (rsp_mem_byte),
      .rsp_mem_addr     (rsp_mem_addr),
      .rsp_mem_wdata    (rsp_mem_wdata),
      .rsp_wait_load    (rsp_wait_load),
      .rsp_status       (rsp_status),
      .rsp_halted       (rsp_halted),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] enc_r(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sa, logic [5:0] fn);
      return {op, rs, rt, rd, sa, fn};
   endfunction

   function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic void write_gpr(logic [4:0] idx, logic [31:0] v);
      if (idx != 5'd0) gpr[idx] = v;
   endfunction

   function automatic void reset_core_state();
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      arch_pc = '0;
      arch_hi = '0;
      arch_lo = '0;
      arch_running = 1'b1;
      load_waiting = 1'b0;
      load_target = '0;
      load_byte = 1'b0;
   endfunction

   function automatic core_result_type execute_item(logic func, logic [31:0] iw,
                                                    logic [31:0] ld);
      core_result_type r;
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd, sa;
      logic [31:0] imm, a, b, seq, npc, btarget;
      logic        ok;
      longint      n, d, q, m;
      r = '0;
      r.status = mips_pkg::ST_OK;
      if (func) begin
         if (load_waiting) begin
            write_gpr(load_target, load_byte ? {{24{ld[7]}}, ld[7:0]} : ld);
            load_waiting = 1'b0;
         end else begin
            r.status = mips_pkg::ST_KIND;
         end
      end else if (load_waiting) begin
         r.status = mips_pkg::ST_KIND;
      end else if (!arch_running) begin
         r.status = mips_pkg::ST_HALTED;
      end else begin
         op = iw[31:26];
         rs = iw[25:21];
         rt = iw[20:16];
         rd = iw[15:11];
         sa = iw[10:6];
         fn = iw[5:0];
         imm = {{16{iw[15]}}, iw[15:0]};
         a = gpr[rs];
         b = gpr[rt];
         n = longint'($signed(a));
         d = longint'($signed(b));
         seq = arch_pc + 32'd4;
         npc = seq;
         btarget = seq + (imm << 2);
         ok = 1'b1;
         case (op)
            mips_pkg::OP_SPECIAL: begin
               case (fn)
                  mips_pkg::FN_SLL:  write_gpr(rd, b << sa);
                  mips_pkg::FN_SRA:  write_gpr(rd, $unsigned($signed(b) >>> sa));
                  mips_pkg::FN_JR:   npc = a;
                  mips_pkg::FN_MOVZ: if (b == 0) write_gpr(rd, a);
                  mips_pkg::FN_MOVN: if (b != 0) write_gpr(rd, a);
                  mips_pkg::FN_MFHI: write_gpr(rd, arch_hi);
                  mips_pkg::FN_MFLO: write_gpr(rd, arch_lo);
                  mips_pkg::FN_MULT: begin
                     q = n * d;
                     arch_hi = q[63:32];
                     arch_lo = q[31:0];
                  end
                  mips_pkg::FN_DIV: begin
                     if (b != 0) begin
                        q = n / d;
                        m = n % d;
                        arch_lo = q[31:0];
                        arch_hi = m[31:0];
                     end
                  end
                  mips_pkg::FN_ADDU: write_gpr(rd, a + b);
                  mips_pkg::FN_SUBU: write_gpr(rd, a - b);
                  mips_pkg::FN_AND:  write_gpr(rd, a & b);
                  mips_pkg::FN_OR:   write_gpr(rd, a | b);
                  mips_pkg::FN_SLT:  write_gpr(rd, {31'd0, $signed(a) < $signed(b)});
                  default: ok = 1'b0;
               endcase
            end
            mips_pkg::OP_REGIMM: begin
               if (rt == 5'd0) begin
                  if (a[31]) npc = btarget;
               end else if (rt == 5'd1) begin
                  if (!a[31]) npc = btarget;
               end else begin
                  ok = 1'b0;
               end
            end
            mips_pkg::OP_J:
               npc = (arch_pc & mips_pkg::REGION_MASK) | {4'd0, iw[25:0], 2'b00};
            mips_pkg::OP_JAL: begin
               write_gpr(5'd31, arch_pc + 32'd8);
               npc = (arch_pc & mips_pkg::REGION_MASK) | {4'd0, iw[25:0], 2'b00};
            end
            mips_pkg::OP_BEQ:   if (a == b) npc = btarget;
            mips_pkg::OP_BNE:   if (a != b) npc = btarget;
            mips_pkg::OP_BLEZ:  if ($signed(a) <= 0) npc = btarget;
            mips_pkg::OP_BGTZ:  if ($signed(a) > 0) npc = btarget;
            mips_pkg::OP_ADDIU: write_gpr(rt, a + imm);
            mips_pkg::OP_SLTI:  write_gpr(rt, {31'd0, $signed(a) < $signed(imm)});
            mips_pkg::OP_SLTIU: write_gpr(rt, {31'd0, a < imm});
            mips_pkg::OP_ANDI:  write_gpr(rt, a & {16'd0, iw[15:0]});
            mips_pkg::OP_ORI:   write_gpr(rt, a | {16'd0, iw[15:0]});
            mips_pkg::OP_LUI:   write_gpr(rt, {iw[15:0], 16'd0});
            mips_pkg::OP_COP0: begin
               if (iw[25] && fn == mips_pkg::FN_WAIT) arch_running = 1'b0;
               else ok = 1'b0;
            end
            mips_pkg::OP_SPECIAL2: begin
               if (fn == mips_pkg::FN_MUL) write_gpr(rd, a * b);
               else ok = 1'b0;
            end
            mips_pkg::OP_SPECIAL3: begin
               if (fn == mips_pkg::FN_EXT)
                  write_gpr(rt, (a >> sa) & (mips_pkg::ALL_ONES >> (5'd31 - rd)));
               else ok = 1'b0;
            end
            mips_pkg::OP_LB, mips_pkg::OP_LW: begin
               r.mem_valid = 1'b1;
               r.mem_byte = (op == mips_pkg::OP_LB);
               r.mem_addr = a + imm;
               load_waiting = 1'b1;
               load_target = rt;
               load_byte = (op == mips_pkg::OP_LB);
            end
            mips_pkg::OP_SB, mips_pkg::OP_SW: begin
               r.mem_valid = 1'b1;
               r.mem_write = 1'b1;
               r.mem_byte = (op == mips_pkg::OP_SB);
               r.mem_addr = a + imm;
               r.mem_wdata = b;
            end
            default: ok = 1'b0;
         endcase
         if (ok) arch_pc = npc;
         else r.status = mips_pkg::ST_UNSUP;
      end
      r.next_pc = arch_pc;
      r.wait_load = load_waiting;
      r.halted = !arch_running;
      return r;
   endfunction

   task automatic send_item(input logic func, input logic [31:0] iw, input logic [31:0] ld);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      awaited_results.push_back(execute_item(func, iw, ld));
      req_valid <= 1'b1;
      req_func <= func;
      req_instr_word <= iw;
      req_load_data <= ld;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_instr(input logic [31:0] iw);
      send_item(1'b0, iw, $urandom);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_start_address(input logic [31:0] v);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      arch_pc = v;
   endtask

   function automatic logic [31:0] random_valid_instr();
      logic [4:0]  rs, rt, rd, sa;
      logic [15:0] imm;
      rs = 5'($urandom_range(31));
      rt = 5'($urandom_range(31));
      rd = 5'($urandom_range(31));
      sa = 5'($urandom_range(31));
      imm = 16'($urandom);
      case ($urandom_range(33))
         0:  return enc_r(mips_pkg::OP_SPECIAL, 5'd0, rt, rd, sa, mips_pkg::FN_SLL);
         1:  return enc_r(mips_pkg::OP_SPECIAL, 5'd0, rt, rd, sa, mips_pkg::FN_SRA);
         2:  return enc_r(mips_pkg::OP_SPECIAL, rs, 5'd0, 5'd0, 5'd0, mips_pkg::FN_JR);
         3:  return enc_r(mips_pkg::OP_SPECIAL, rs, rt, rd, 5'd0, mips_pkg::FN_MOVZ);
         4:  return enc_r(mips_pkg::OP_SPECIAL, rs, rt, rd, 5'd0, mips_pkg::FN_MOVN);
         5:  return enc_r(mips_pkg::OP_SPECIAL, 5'd0, 5'd0, rd, 5'd0, mips_pkg::FN_MFHI);
         6:  return enc_r(mips_pkg::OP_SPECIAL, 5'd0, 5'd0, rd, 5'd0, mips_pkg::FN_MFLO);
         7:  return enc_r(mips_pkg::OP_SPECIAL, rs, rt, 5'd0, 5'd0, mips_pkg::FN_MULT);
         8:  return enc_r(mips_pkg::OP_SPECIAL, rs, rt, 5'd0, 5'd0, mips_pkg::FN_DIV);
         9:  return enc_r(mips_pkg::OP_SPECIAL, rs, rt, rd, 5'd0, mips_pkg::FN_ADDU);
         10: return enc_r(mips_pkg::OP_SPECIAL, rs, rt, rd, 5'd0, mips_pkg::FN_SUBU);
         11: return enc_r(mips_pkg::OP_SPECIAL, rs, rt, rd, 5'd0, mips_pkg::FN_AND);
         12: return enc_r(mips_pkg::OP_SPECIAL, rs, rt, rd, 5'd0, mips_pkg::FN_OR);
         13: return enc_r(mips_pkg::OP_SPECIAL, rs, rt, rd, 5'd0, mips_pkg::FN_SLT);
         14: return enc_i(mips_pkg::OP_REGIMM, rs, 5'd0, imm);
         15: return enc_i(mips_pkg::OP_REGIMM, rs, 5'd1, imm);
         16: return {mips_pkg::OP_J, 26'($urandom)};
         17: return {mips_pkg::OP_JAL, 26'($urandom)};
         18: return enc_i(mips_pkg::OP_BEQ, rs, rt, imm);
         19: return enc_i(mips_pkg::OP_BNE, rs, rt, imm);
         20: return enc_i(mips_pkg::OP_BLEZ, rs, 5'd0, imm);
         21: return enc_i(mips_pkg::OP_BGTZ, rs, 5'd0, imm);
         22: return enc_i(mips_pkg::OP_ADDIU, rs, rt, imm);
         23: return enc_i(mips_pkg::OP_SLTI, rs, rt, imm);
         24: return enc_i(mips_pkg::OP_SLTIU, rs, rt, imm);
         25: return enc_i(mips_pkg::OP_ANDI, rs, rt, imm);
         26: return enc_i(mips_pkg::OP_ORI, rs, rt, imm);
         27: return enc_i(mips_pkg::OP_LUI, 5'd0, rt, imm);
         28: return enc_r(mips_pkg::OP_SPECIAL2, rs, rt, rd, 5'd0, mips_pkg::FN_MUL);
         29: return enc_r(mips_pkg::OP_SPECIAL3, rs, rt, rd, sa, mips_pkg::FN_EXT);
         30: return enc_i(mips_pkg::OP_LB, rs, rt, imm);
         31: return enc_i(mips_pkg::OP_LW, rs, rt, imm);
         32: return enc_i(mips_pkg::OP_SB, rs, rt, imm);
         default: return enc_i(mips_pkg::OP_SW, rs, rt, imm);
      endcase
   endfunction

   task automatic send_random_items(input int count);
      logic [31:0] w;
      for (int i = 0; i < count; i++) begin
         if (load_waiting) begin
            if ($urandom_range(99) < 90) send_item(1'b1, $urandom, $urandom);
            else send_instr(random_valid_instr());
         end else begin
            case ($urandom_range(99))
               0, 1, 2: send_item(1'b1, $urandom, $urandom);
               3, 4, 5, 6: begin
                  w = $urandom;
                  // keep the core running: drop a stray WAIT encoding
                  if (w[31:26] == mips_pkg::OP_COP0 && w[5:0] == mips_pkg::FN_WAIT)
                     w[25] = 1'b0;
                  send_instr(w);
               end
               default: send_instr(random_valid_instr());
            endcase
         end
      end
   endtask

   task automatic test_alu();
      send_instr(enc_i(mips_pkg::OP_LUI, 5'd0, 5'd1, 16'h8000));
      send_instr(enc_i(mips_pkg::OP_ADDIU, 5'd0, 5'd2, 16'hFFFF));
      send_instr(enc_r(mips_pkg::OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, mips_pkg::FN_ADDU));
      send_instr(enc_r(mips_pkg::OP_SPECIAL, 5'd0, 5'd1, 5'd4, 5'd31, mips_pkg::FN_SRA));
      send_instr(enc_r(mips_pkg::OP_SPECIAL, 5'd0, 5'd2, 5'd5, 5'd31, mips_pkg::FN_SLL));
      send_instr(enc_i(mips_pkg::OP_ANDI, 5'd2, 5'd6, 16'hFFFF));
      send_instr(enc_i(mips_pkg::OP_SLTIU, 5'd0, 5'd7, 16'hFFFF));
      send_instr(enc_r(mips_pkg::OP_SPECIAL, 5'd1, 5'd3, 5'd8, 5'd0, mips_pkg::FN_SLT));
      send_instr(enc_r(mips_pkg::OP_SPECIAL3, 5'd2, 5'd9, 5'd31, 5'd31, mips_pkg::FN_EXT));
      send_instr(enc_r(mips_pkg::OP_SPECIAL2, 5'd3, 5'd3, 5'd0, 5'd0, mips_pkg::FN_MUL));
      send_instr(enc_r(mips_pkg::OP_SPECIAL, 5'd1, 5'd0, 5'd10, 5'd0, mips_pkg::FN_MOVZ));
   endtask

   task automatic test_hilo();
      send_instr(enc_r(mips_pkg::OP_SPECIAL, 5'd1, 5'd1, 5'd0, 5'd0, mips_pkg::FN_MULT));
      send_instr(enc_r(mips_pkg::OP_SPECIAL, 5'd1, 5'd0, 5'd0, 5'd0, mips_pkg::FN_DIV));
      send_instr(enc_r(mips_pkg::OP_SPECIAL, 5'd0, 5'd0, 5'd11, 5'd0, mips_pkg::FN_MFHI));
      send_instr(enc_r(mips_pkg::OP_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd0, mips_pkg::FN_DIV));
      send_instr(enc_r(mips_pkg::OP_SPECIAL, 5'd0, 5'd0, 5'd12, 5'd0, mips_pkg::FN_MFLO));
      send_instr(enc_r(mips_pkg::OP_SPECIAL, 5'd0, 5'd0, 5'd13, 5'd0, mips_pkg::FN_MFHI));
   endtask

   task automatic test_branches();
      send_instr(enc_i(mips_pkg::OP_REGIMM, 5'd1, 5'd0, 16'h8000));
      send_instr(enc_i(mips_pkg::OP_REGIMM, 5'd0, 5'd1, 16'h7FFF));
      send_instr(enc_i(mips_pkg::OP_REGIMM, 5'd0, 5'd2, 16'h0000));
      send_instr(enc_i(mips_pkg::OP_BEQ, 5'd0, 5'd0, 16'hFFFF));
      send_instr(enc_i(mips_pkg::OP_BNE, 5'd1, 5'd2, 16'h0004));
      send_instr(enc_i(mips_pkg::OP_BLEZ, 5'd0, 5'd0, 16'h0010));
      send_instr(enc_i(mips_pkg::OP_BGTZ, 5'd7, 5'd0, 16'hFFF0));
      send_instr({mips_pkg::OP_J, 26'h3FF_FFFF});
      send_instr({mips_pkg::OP_JAL, 26'h000_0001});
      send_instr(enc_r(mips_pkg::OP_SPECIAL, 5'd2, 5'd0, 5'd0, 5'd0, mips_pkg::FN_JR));
   endtask

   task automatic test_memory();
      send_instr(enc_i(mips_pkg::OP_SW, 5'd2, 5'd1, 16'h7FFF));
      send_instr(enc_i(mips_pkg::OP_SB, 5'd1, 5'd2, 16'h8000));
      send_instr(enc_i(mips_pkg::OP_LB, 5'd0, 5'd14, 16'h0001));
      send_instr(enc_i(mips_pkg::OP_ADDIU, 5'd0, 5'd1, 16'h0001));
      send_item(1'b1, '0, 32'h1234_5680);
      send_instr(enc_i(mips_pkg::OP_LW, 5'd2, 5'd0, 16'hFFFC));
      send_item(1'b1, '1, 32'hFFFF_FFFF);
      send_item(1'b1, '0, 32'hA5A5_A5A5);
      send_instr(32'hFFFF_FFFF);
      send_instr(enc_r(mips_pkg::OP_SPECIAL, 5'd0, 5'd0, 5'd0, 5'd0, 6'h3F));
   endtask

   task automatic test_random_phases();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      send_random_items(500);
      write_start_address(32'hFFFF_FFFC);
      sender_idle_pct = 76;
      send_random_items(500);
      write_start_address($urandom);
      sender_idle_pct = 0;
      receiver_stall_pct = 76;
      send_random_items(500);
      write_start_address(32'hFFFF_FFFF);
      sender_idle_pct = 8;
      receiver_stall_pct = 8;
      send_random_items(500);
   endtask

   task automatic test_back_pressure();
      drain_results();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_off_cycles = 400;
      send_random_items(40);
   endtask

   task automatic test_halt();
      write_start_address(32'h0000_0000);
      send_instr({mips_pkg::OP_COP0, 1'b1, 19'd0, mips_pkg::FN_WAIT});
      send_instr(enc_i(mips_pkg::OP_ADDIU, 5'd0, 5'd1, 16'h0001));
      send_item(1'b1, '0, 32'h0000_00FF);
      send_instr(enc_i(mips_pkg::OP_LW, 5'd0, 5'd1, 16'h0000));
   endtask

   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      core_result_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_next_pc, rsp_mem_valid, rsp_mem_write, rsp_mem_byte, rsp_mem_addr,
                 rsp_mem_wdata, rsp_wait_load, rsp_status, rsp_halted};
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result item: %p", got);
         end else begin
            want = awaited_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset_core_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_alu();
      test_hilo();
      write_start_address(32'hF000_0000);
      test_branches();
      test_memory();
      test_random_phases();
      test_back_pressure();
      test_halt();
      drain_results();
      if (mismatch_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/mips_pkg.sv
hw/rtl/mips_div.sv
hw/rtl/mips32_subset_execute_step.sv
tb/tb_mips32_subset_execute_step.sv
